// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file rcfe_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rcfe_pkg.sv =====
// Types, constants and helper functions of the clock field editor.
// No dependencies; imported by all rcfe modules.
package rcfe_pkg;

  localparam int HOLDOFF_W = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [HOLDOFF_W-1:0] ROTATE_HOLDOFF_RST = 16'd100;
  localparam logic [HOLDOFF_W-1:0] KEY_HOLDOFF_RST    = 16'd300;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_HOLDOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOLDOFF    = 1'b1;

  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_KEY    = 1'b1;

  localparam logic [7:0] REG_YR  = 8'h8C;
  localparam logic [7:0] REG_MON = 8'h88;
  localparam logic [7:0] REG_DAY = 8'h86;
  localparam logic [7:0] REG_HR  = 8'h84;
  localparam logic [7:0] REG_MIN = 8'h82;

  typedef enum logic [2:0] {
    FOC_YR  = 3'd0,
    FOC_MON = 3'd1,
    FOC_DAY = 3'd2,
    FOC_HR  = 3'd3,
    FOC_MIN = 3'd4
  } field_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] event_time;
    logic              phase_a_level;
    logic              phase_b_level;
    logic [7:0]        field_raw;
  } item_t;

  typedef struct packed {
    logic              edit_flag;
    field_t            focus;
    logic [TIME_W-1:0] rot_stamp;
    logic [TIME_W-1:0] key_stamp;
  } state_t;

  typedef struct packed {
    logic       accepted;
    logic       edit_active;
    logic [2:0] focus_field;
    logic       write_enable;
    logic [7:0] write_address;
    logic [7:0] write_data;
    logic       clear_seconds;
  } result_t;

  function automatic logic too_early(input logic [TIME_W-1:0]    now,
                                     input logic [TIME_W-1:0]    last,
                                     input logic [HOLDOFF_W-1:0] holdoff);
    logic [TIME_W-1:0] d;
    d = now - last - {{(TIME_W-HOLDOFF_W){1'b0}}, holdoff};
    return d[TIME_W-1];
  endfunction

  function automatic logic [6:0] fld_lo(input field_t f);
    case (f)
      FOC_MON, FOC_DAY: return 7'd1;
      default:          return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] fld_hi(input field_t f);
    case (f)
      FOC_YR:  return 7'd99;
      FOC_MON: return 7'd12;
      FOC_DAY: return 7'd31;
      FOC_HR:  return 7'd23;
      FOC_MIN: return 7'd59;
      default: return 7'd99;
    endcase
  endfunction

  function automatic logic [7:0] fld_reg(input field_t f);
    case (f)
      FOC_YR:  return REG_YR;
      FOC_MON: return REG_MON;
      FOC_DAY: return REG_DAY;
      FOC_HR:  return REG_HR;
      FOC_MIN: return REG_MIN;
      default: return REG_YR;
    endcase
  endfunction

endpackage

// ===== hw/rtl/rotary_clock_field_editor_core.sv =====
// Clock field editor top level: input register, evaluation, result register.
// Depends on rcfe_pkg and rcfe_eval.
// An accepted item passes through the input register and the result register to
// out_valid. Throughput: one item per cycle while out_stall is low; state
// updates as an item leaves the input register. A held result stalls the input.
// Reset (synchronous, rst_n low): empty, navigate, year, times 0, hold-offs 100/300.
module rotary_clock_field_editor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rcfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcfe_pkg::HOLDOFF_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [rcfe_pkg::TIME_W-1:0]       in_event_time,
  input  logic                              in_phase_a_level,
  input  logic                              in_phase_b_level,
  input  logic [7:0]                        in_field_raw,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic                              out_edit_active,
  output logic [2:0]                        out_focus_field,
  output logic                              out_write_enable,
  output logic [7:0]                        out_write_address,
  output logic [7:0]                        out_write_data,
  output logic                              out_clear_seconds
);
  import rcfe_pkg::*;

  logic [HOLDOFF_W-1:0] rot_holdoff_r;
  logic [HOLDOFF_W-1:0] key_holdoff_r;
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  item_t                s1_item_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  result_t              out_res_r;
  state_t               st_r;
  state_t               st_nxt;
  result_t              res;
  logic                 in_take;
  logic                 s1_adv;

  assign s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_adv;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_holdoff_r <= ROTATE_HOLDOFF_RST;
      key_holdoff_r <= KEY_HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROTATE_HOLDOFF: rot_holdoff_r <= cfg_wdata;
        CFG_KEY_HOLDOFF:    key_holdoff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{edit_flag: 1'b0, focus: FOC_YR,
                       rot_stamp: '0, key_stamp: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{mode: in_mode, event_time: in_event_time,
                     phase_a_level: in_phase_a_level,
                     phase_b_level: in_phase_b_level, field_raw: in_field_raw};
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  rcfe_eval u_eval (
    .item           (s1_item_r),
    .st             (st_r),
    .rotate_holdoff (rot_holdoff_r),
    .key_holdoff    (key_holdoff_r),
    .res            (res),
    .st_nxt         (st_nxt)
  );

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_res_r.accepted;
  assign out_edit_active   = out_res_r.edit_active;
  assign out_focus_field   = out_res_r.focus_field;
  assign out_write_enable  = out_res_r.write_enable;
  assign out_write_address = out_res_r.write_address;
  assign out_write_data    = out_res_r.write_data;
  assign out_clear_seconds = out_res_r.clear_seconds;

endmodule

// ===== hw/rtl/rcfe_step.sv =====
// Field value stepper: BCD byte to binary, +/-1 with wrap, back to BCD.
// Depends on rcfe_pkg.
module rcfe_step (
  input  rcfe_pkg::field_t field,
  input  logic [7:0]       raw,
  input  logic             up,
  output logic [7:0]       wr_addr,
  output logic [7:0]       wr_data
);
  import rcfe_pkg::*;

  logic [7:0]  cur;
  logic [8:0]  inc;
  logic [6:0]  lo;
  logic [6:0]  hi;
  logic [6:0]  nv;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones;

  assign lo  = fld_lo(field);
  assign hi  = fld_hi(field);
  // nibbles taken as 0..15 each
  assign cur = {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0} + {4'b0000, raw[3:0]};
  assign inc = {1'b0, cur} + 9'd1;

  always_comb begin
    if (up) begin
      nv = (inc > {2'b00, hi}) ? lo : inc[6:0];
    end else begin
      nv = (cur <= {1'b0, lo} || cur > {1'b0, hi}) ? hi : 7'(cur - 8'd1);
    end
  end

  // nv <= 99: divide by 10 via multiply by 205 >> 11
  assign prod = {8'b0, nv} * 15'd205;
  assign tens = prod[14:11];
  assign ones = nv - ({tens, 3'b000} + {2'b00, tens, 1'b0});

  assign wr_addr = fld_reg(field);
  assign wr_data = {tens, ones[3:0]};

endmodule

// ===== hw/rtl/rcfe_eval.sv =====
// Per-item evaluation: hold-off check, mode toggle, focus move, field write.
// Depends on rcfe_pkg and rcfe_step.
module rcfe_eval (
  input  rcfe_pkg::item_t                   item,
  input  rcfe_pkg::state_t                  st,
  input  logic [rcfe_pkg::HOLDOFF_W-1:0]    rotate_holdoff,
  input  logic [rcfe_pkg::HOLDOFF_W-1:0]    key_holdoff,
  output rcfe_pkg::result_t                 res,
  output rcfe_pkg::state_t                  st_nxt
);
  import rcfe_pkg::*;

  field_t     focus;
  logic       up;
  logic       key_early;
  logic       rot_early;
  logic [7:0] wr_addr;
  logic [7:0] wr_data;

  always_comb begin
    case (st.focus)
      FOC_YR, FOC_MON, FOC_DAY, FOC_HR, FOC_MIN: focus = st.focus;
      default: focus = FOC_YR;
    endcase
  end

  assign up        = item.phase_b_level;
  assign key_early = too_early(item.event_time, st.key_stamp, key_holdoff);
  assign rot_early = too_early(item.event_time, st.rot_stamp, rotate_holdoff);

  rcfe_step u_step (
    .field   (focus),
    .raw     (item.field_raw),
    .up      (up),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    st_nxt            = st;
    st_nxt.focus      = focus;
    res               = '0;
    if (item.mode == MODE_KEY) begin
      if (!key_early) begin
        res.accepted     = 1'b1;
        st_nxt.key_stamp = item.event_time;
        st_nxt.edit_flag = ~st.edit_flag;
      end
    end else if (!rot_early) begin
      res.accepted     = 1'b1;
      st_nxt.rot_stamp = item.event_time;
      if (!item.phase_a_level) begin
        if (!st.edit_flag) begin
          case (focus)
            FOC_YR:  st_nxt.focus = up ? FOC_MON : FOC_MIN;
            FOC_MON: st_nxt.focus = up ? FOC_DAY : FOC_YR;
            FOC_DAY: st_nxt.focus = up ? FOC_HR  : FOC_MON;
            FOC_HR:  st_nxt.focus = up ? FOC_MIN : FOC_DAY;
            FOC_MIN: st_nxt.focus = up ? FOC_YR  : FOC_HR;
            default: st_nxt.focus = FOC_YR;
          endcase
        end else begin
          res.write_enable  = 1'b1;
          res.write_address = wr_addr;
          res.write_data    = wr_data;
          res.clear_seconds = (focus == FOC_MIN);
        end
      end
    end
    res.edit_active = st_nxt.edit_flag;
    res.focus_field = st_nxt.focus;
  end

endmodule

// ===== hw/rtl/rcfe_checker.sv =====
// Port-level checker for the clock field editor, bound to the top level.
// Depends on rcfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_accepted,
  input logic [2:0] out_focus_field,
  input logic       out_write_enable,
  input logic [7:0] out_write_address,
  input logic [7:0] out_write_data,
  input logic       out_clear_seconds
);
  import rcfe_pkg::*;

  logic quiet_ok;
  logic min_write;

  assign quiet_ok  = out_write_address == 8'h00 && out_write_data == 8'h00 &&
                     !out_clear_seconds;
  assign min_write = out_write_enable && out_write_address == REG_MIN &&
                     out_focus_field == FOC_MIN;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMPLIES(a_no_write_quiet, clk, rst_n, out_valid && !out_write_enable, quiet_ok)
  `ASSERT_IMPLIES(a_write_needs_accept, clk, rst_n, out_valid && out_write_enable, out_accepted)
  `ASSERT_IMPLIES(a_sec_clear_minute, clk, rst_n, out_valid && out_clear_seconds, min_write)
  `ASSERT_ALWAYS(a_focus_range, clk, rst_n, !out_valid || out_focus_field <= FOC_MIN)

endmodule

bind rotary_clock_field_editor_core rcfe_checker u_rcfe_checker (.*);

// ===== test/testbench.sv =====
// Self-checking bench for rotary_clock_field_editor_core: hold-off filtering,
// focus navigation, edit-mode BCD stepping with wrap, and back-pressure.
// Depends on rcfe_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfe_pkg::*;

  localparam int CHOKE_CYCLES = 250;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HOLDOFF_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [TIME_W-1:0]    in_event_time;
  logic                 in_phase_a_level;
  logic                 in_phase_b_level;
  logic [7:0]           in_field_raw;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_accepted;
  logic                 out_edit_active;
  logic [2:0]           out_focus_field;
  logic                 out_write_enable;
  logic [7:0]           out_write_address;
  logic [7:0]           out_write_data;
  logic                 out_clear_seconds;

  rotary_clock_field_editor_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_event_time     (in_event_time),
    .in_phase_a_level  (in_phase_a_level),
    .in_phase_b_level  (in_phase_b_level),
    .in_field_raw      (in_field_raw),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_edit_active   (out_edit_active),
    .out_focus_field   (out_focus_field),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_clear_seconds (out_clear_seconds)
  );

  // Editor state as the bench sees it
  logic [15:0] rot_hold, key_hold;
  logic        edit_mode;
  field_t      focus;
  logic [31:0] last_rot_ms, last_key_ms;

  result_t     pending_results[$];
  int          error_count;
  logic [31:0] now_ms;
  int          burst_left;
  bit          gaps_on;
  int          stall_pct;
  bit          choke_req;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic bit clears_holdoff(input logic [31:0] now, input logic [31:0] last,
                                        input logic [15:0] hold);
    logic [31:0] d;
    d = now - last - {16'd0, hold};
    return !d[31];
  endfunction

  function automatic result_t predict_event(input item_t it);
    result_t    r;
    logic [7:0] cur, nxt, lo, hi, addr;
    r = '0;
    if (it.mode == MODE_KEY) begin
      if (clears_holdoff(it.event_time, last_key_ms, key_hold)) begin
        r.accepted  = 1'b1;
        last_key_ms = it.event_time;
        edit_mode   = !edit_mode;
      end
    end else if (clears_holdoff(it.event_time, last_rot_ms, rot_hold)) begin
      r.accepted  = 1'b1;
      last_rot_ms = it.event_time;
      if (!it.phase_a_level) begin
        if (!edit_mode) begin
          if (it.phase_b_level)
            focus = (focus == FOC_MIN) ? FOC_YR : field_t'(focus + 3'd1);
          else
            focus = (focus == FOC_YR) ? FOC_MIN : field_t'(focus - 3'd1);
        end else begin
          case (focus)
            FOC_MON: begin lo = 8'd1; hi = 8'd12; addr = REG_MON; end
            FOC_DAY: begin lo = 8'd1; hi = 8'd31; addr = REG_DAY; end
            FOC_HR:  begin lo = 8'd0; hi = 8'd23; addr = REG_HR;  end
            FOC_MIN: begin lo = 8'd0; hi = 8'd59; addr = REG_MIN; end
            default: begin lo = 8'd0; hi = 8'd99; addr = REG_YR;  end
          endcase
          // nibbles read as 0..15 even when not decimal
          cur = it.field_raw[7:4] * 8'd10 + it.field_raw[3:0];
          if (it.phase_b_level)
            nxt = (cur + 8'd1 > hi) ? lo : cur + 8'd1;
          else
            nxt = (cur <= lo || cur > hi) ? hi : cur - 8'd1;
          r.write_enable  = 1'b1;
          r.write_address = addr;
          r.write_data    = to_bcd(nxt);
          r.clear_seconds = (focus == FOC_MIN);
        end
      end
    end
    r.edit_active = edit_mode;
    r.focus_field = focus;
    return r;
  endfunction

  // Result checker
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 8'(want.accepted), 8'(out_accepted));
        check_field("edit_active", 8'(want.edit_active), 8'(out_edit_active));
        check_field("focus_field", 8'(want.focus_field), 8'(out_focus_field));
        check_field("write_enable", 8'(want.write_enable), 8'(out_write_enable));
        check_field("write_address", want.write_address, out_write_address);
        check_field("write_data", want.write_data, out_write_data);
        check_field("clear_seconds", 8'(want.clear_seconds), 8'(out_clear_seconds));
      end
    end
  end

  // Receiver: stall runs of random length, plus a long hold-off on request
  initial begin
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        out_stall <= 1'b1;
        repeat (CHOKE_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        choke_req = 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        run = $urandom_range(0, 7);
      end
    end
  end

  // Sender; called and returns at a falling edge
  task automatic send_event(input item_t it);
    in_valid         <= 1'b1;
    in_mode          <= it.mode;
    in_event_time    <= it.event_time;
    in_phase_a_level <= it.phase_a_level;
    in_phase_b_level <= it.phase_b_level;
    in_field_raw     <= it.field_raw;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_event(it));
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_now(input logic mode, input logic [31:0] t, input logic pa,
                          input logic pb, input logic [7:0] raw);
    item_t it;
    it.mode          = mode;
    it.event_time    = t;
    it.phase_a_level = pa;
    it.phase_b_level = pb;
    it.field_raw     = raw;
    send_event(it);
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_holdoff(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROTATE_HOLDOFF) rot_hold = val;
    else key_hold = val;
  endtask

  // Mostly well-spaced events; noise_pct of them are early, late or jumpy
  task automatic play_random(input int count, input int noise_pct);
    item_t       it;
    logic [31:0] hold;
    repeat (count) begin
      it.mode = ($urandom_range(0, 99) < 18) ? MODE_KEY : MODE_ROTATE;
      hold = (it.mode == MODE_KEY) ? {16'd0, key_hold} : {16'd0, rot_hold};
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0:       now_ms += $urandom_range(0, 32'h3FFF_FFFF);
          1:       now_ms += $urandom_range(0, hold);
          2:       now_ms -= $urandom_range(0, 64);
          default: now_ms = $urandom();
        endcase
      end else begin
        now_ms += hold + $urandom_range(0, 300);
      end
      it.event_time    = now_ms;
      it.phase_a_level = ($urandom_range(0, 99) < 12);
      it.phase_b_level = 1'($urandom_range(0, 1));
      it.field_raw     = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                     : to_bcd(8'($urandom_range(0, 99)));
      send_event(it);
      pace();
    end
  endtask

  task automatic test_directed();
    send_now(MODE_ROTATE, 0, 0, 1, 8'h00);      // inside window of time 0
    send_now(MODE_ROTATE, 99, 0, 1, 8'h00);
    send_now(MODE_ROTATE, 100, 0, 1, 8'h00);    // focus to month
    send_now(MODE_ROTATE, 200, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 300, 0, 0, 8'h00);    // wraps down to minute
    send_now(MODE_ROTATE, 400, 0, 1, 8'h00);    // wraps up to year
    send_now(MODE_ROTATE, 500, 1, 1, 8'h42);    // phase A high
    send_now(MODE_KEY, 299, 0, 0, 8'h00);
    send_now(MODE_KEY, 32'hFFFF_FFFF, 0, 0, 8'h00);
    send_now(MODE_KEY, 300, 0, 0, 8'h00);       // edit
    send_now(MODE_ROTATE, 600, 0, 1, 8'h99);
    send_now(MODE_ROTATE, 700, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 800, 0, 1, 8'hFF);    // non-decimal, above max
    send_now(MODE_ROTATE, 900, 0, 0, 8'hFF);
    send_now(MODE_KEY, 1000, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 1100, 0, 1, 8'h00);
    send_now(MODE_KEY, 1400, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 1500, 0, 1, 8'h00);   // month below min
    send_now(MODE_ROTATE, 1600, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 1700, 0, 1, 8'h12);
    send_now(MODE_ROTATE, 1800, 0, 0, 8'h1A);
    send_now(MODE_KEY, 1900, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 2000, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 2100, 0, 0, 8'h00);
    send_now(MODE_KEY, 2200, 0, 0, 8'h00);
    send_now(MODE_ROTATE, 2300, 0, 1, 8'h59);   // minute write clears seconds
    drain();
  endtask

  task automatic test_holdoff_extremes();
    set_holdoff(CFG_ROTATE_HOLDOFF, 16'd0);
    set_holdoff(CFG_KEY_HOLDOFF, 16'd0);
    send_now(MODE_ROTATE, 5000, 0, 1, 8'h07);
    send_now(MODE_ROTATE, 5000, 0, 1, 8'h07);
    send_now(MODE_ROTATE, 4999, 0, 1, 8'h07);
    send_now(MODE_KEY, 6000, 0, 0, 8'h00);
    send_now(MODE_KEY, 6000, 0, 0, 8'h00);
    now_ms = 6000;
    play_random(130, 20);
    drain();
    set_holdoff(CFG_ROTATE_HOLDOFF, 16'hFFFF);
    set_holdoff(CFG_KEY_HOLDOFF, 16'hFFFF);
    play_random(130, 20);
    drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_holdoff(CFG_ROTATE_HOLDOFF, 16'($urandom_range(1, 400)));
          set_holdoff(CFG_KEY_HOLDOFF, 16'($urandom_range(1, 1000)));
        end
        1: begin
          set_holdoff(CFG_ROTATE_HOLDOFF, 16'd0);
          set_holdoff(CFG_KEY_HOLDOFF, 16'hFFFF);
        end
        2: begin
          set_holdoff(CFG_ROTATE_HOLDOFF, 16'hFFFF);
          set_holdoff(CFG_KEY_HOLDOFF, 16'd0);
          now_ms = 32'hFFFF_0000;
        end
        default: begin
          set_holdoff(CFG_ROTATE_HOLDOFF, 16'($urandom()));
          set_holdoff(CFG_KEY_HOLDOFF, 16'($urandom()));
        end
      endcase
      stall_pct = 15 * phase;
      play_random(250, 15);
      drain();
    end
  endtask

  task automatic test_back_pressure();
    set_holdoff(CFG_ROTATE_HOLDOFF, ROTATE_HOLDOFF_RST);
    set_holdoff(CFG_KEY_HOLDOFF, KEY_HOLDOFF_RST);
    stall_pct = 30;
    choke_req = 1'b1;
    play_random(100, 10);
    drain();
  endtask

  task automatic test_full_rate();
    gaps_on   = 1'b0;
    stall_pct = 0;
    play_random(150, 10);
    drain();
    gaps_on   = 1'b1;
    stall_pct = 25;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_mode          = 1'b0;
    in_event_time    = '0;
    in_phase_a_level = 1'b0;
    in_phase_b_level = 1'b0;
    in_field_raw     = '0;
    rot_hold         = 16'd100;
    key_hold         = 16'd300;
    edit_mode        = 1'b0;
    focus            = FOC_YR;
    last_rot_ms      = '0;
    last_key_ms      = '0;
    error_count      = 0;
    now_ms           = '0;
    burst_left       = 0;
    gaps_on          = 1'b1;
    stall_pct        = 25;
    choke_req        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_holdoff_extremes();
    test_random_traffic();
    test_back_pressure();
    test_full_rate();

    repeat (10) @(negedge clk);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
